[sv/smlt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smlt_pkg: shared definitions of the source MAC learning table
// Table size, field widths, command codes, controller states and the
// control bundle that the controller broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package smlt_pkg;

	// table geometry
	localparam int DEPTH  = 64;
	localparam int LANES  = 8;
	localparam int GROUPS = (DEPTH + LANES - 1) / LANES;

	// field widths
	localparam int MAC_W  = 48;
	localparam int IDX_W  = 6;
	localparam int FILL_W = 7;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SCAN_W = $clog2(GROUPS + 1);

	// request commands
	typedef enum logic {
		CMD_LEARN = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DONE
	} state_t;

	// broadcast control for every cell of the row
	typedef struct packed {
		logic             load;
		logic             scan;
		logic             wr_new;
		logic             wr_shift;
		logic             is_read;
		logic [MAC_W-1:0] mac;
	} cell_ctl_t;

endpackage
`default_nettype wire

[sv/smlt_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smlt_req_if: request channel of the learning table
// Valid/ready handshake carrying a command, a source MAC and a position.
// ----------------------------------------------------------------------------
interface smlt_req_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [smlt_pkg::MAC_W-1:0]  mac_address;
	logic [smlt_pkg::IDX_W-1:0]  entry_index;

	modport source (output valid, output cmd, output mac_address, output entry_index,
		input ready);
	modport sink (input valid, input cmd, input mac_address, input entry_index,
		output ready);
endinterface
`default_nettype wire

[sv/smlt_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smlt_rsp_if: response channel of the learning table
// Valid/ready handshake carrying hit, learned, the entry MAC and fill count.
// ----------------------------------------------------------------------------
interface smlt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic                        learned;
	logic [smlt_pkg::MAC_W-1:0]  entry_mac;
	logic [smlt_pkg::FILL_W-1:0] fill_count;

	modport source (output valid, output hit, output learned, output entry_mac,
		output fill_count, input ready);
	modport sink (input valid, input hit, input learned, input entry_mac,
		input fill_count, output ready);
endinterface
`default_nettype wire

[sv/smlt_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smlt_cell: one entry of the learning table
// Holds one MAC, compares it against the broadcast address, and keeps a tap
// (flag and data) that moves down the row toward the collector.
// ----------------------------------------------------------------------------
module smlt_cell (
	input  wire logic                       clk,
	input  wire smlt_pkg::cell_ctl_t        ctl,
	input  wire logic                       sel,
	input  wire logic                       valid,
	input  wire logic                       append,
	input  wire logic [smlt_pkg::MAC_W-1:0] next_mac,
	input  wire logic                       tap_flag_in,
	input  wire logic [smlt_pkg::MAC_W-1:0] tap_data_in,
	output logic      [smlt_pkg::MAC_W-1:0] mac,
	output logic                            tap_flag,
	output logic      [smlt_pkg::MAC_W-1:0] tap_data
);
	import smlt_pkg::*;

	logic [MAC_W-1:0] mac_q;
	logic             tap_flag_q;
	logic [MAC_W-1:0] tap_data_q;
	logic             match;
	logic             picked;

	// address compare and position select
	assign match  = valid && (mac_q == ctl.mac);
	assign picked = valid && sel;

	// tap: capture this cell's answer, then pass along the row
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			tap_flag_q <= ctl.is_read ? picked : match;
			tap_data_q <= (ctl.is_read && picked) ? mac_q : '0;
		end else if (ctl.scan) begin
			tap_flag_q <= tap_flag_in;
			tap_data_q <= tap_data_in;
		end
	end

	// entry: append at the tail, or move one place toward the oldest end
	always_ff @(posedge clk) begin
		if (ctl.wr_new && append) begin
			mac_q <= ctl.mac;
		end else if (ctl.wr_shift) begin
			mac_q <= next_mac;
		end
	end

	assign mac      = mac_q;
	assign tap_flag = tap_flag_q;
	assign tap_data = tap_data_q;

endmodule
`default_nettype wire

[sv/source_mac_learning_table.sv]
`default_nettype none
// Flow: a request is taken only in the idle state. The controller then loads the
// cell taps, sweeps the row LANES cells per cycle to collect the answer, writes
// any newly learned address into the row and registers the response. A new
// request is taken only once the controller is idle again and the output stage
// is free, so a response held by the receiver holds off the next request.
// Reset: empty table, no response pending; stored MACs are not cleared.
// ----------------------------------------------------------------------------
// source_mac_learning_table: FIFO-replacement source MAC learning table
// A row of cells kept in arrival order, oldest in cell 0. Learn requests add
// absent addresses at the tail, shifting the row out of the oldest when full.
// Read requests return the entry at a position counted from the oldest.
// ----------------------------------------------------------------------------
module source_mac_learning_table (
	input wire logic   clk,
	input wire logic   arst_n,
	smlt_req_if.sink   req,
	smlt_rsp_if.source rsp
);
	import smlt_pkg::*;

	state_t           state_q, state_d;
	cell_ctl_t        ctl;
	logic             req_fire;
	logic             learn_new;
	logic             full;
	logic [CNT_W-1:0] cnt_next;

	logic             cmd_q;
	logic [MAC_W-1:0] mac_q;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SCAN_W-1:0] grp_q;
	logic             hit_acc_q;
	logic [MAC_W-1:0] data_acc_q;
	logic             lane_flag;
	logic [MAC_W-1:0] lane_data;

	logic              rsp_valid_q;
	logic              rsp_hit_q;
	logic              rsp_learned_q;
	logic [MAC_W-1:0]  rsp_mac_q;
	logic [FILL_W-1:0] rsp_fill_q;

	logic [MAC_W-1:0] cell_mac  [DEPTH];
	logic             cell_flag [DEPTH];
	logic [MAC_W-1:0] cell_data [DEPTH];

	// request handshake: take a new request once the output stage is free
	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign learn_new = (cmd_q == CMD_LEARN) && !hit_acc_q;
	assign cnt_next  = (learn_new && !full) ? cnt_q + CNT_W'(1) : cnt_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and cell control
	always_comb begin
		state_d      = state_q;
		ctl.load     = 1'b0;
		ctl.scan     = 1'b0;
		ctl.wr_new   = 1'b0;
		ctl.wr_shift = 1'b0;
		ctl.is_read  = (cmd_q == CMD_READ);
		ctl.mac      = mac_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (grp_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				ctl.wr_new   = learn_new && !full;
				ctl.wr_shift = learn_new && full;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= req.cmd;
			mac_q <= req.mac_address;
			pos_q <= req.entry_index;
		end
	end

	// lanes collected this cycle from the head of the row
	always_comb begin
		lane_flag = 1'b0;
		lane_data = '0;
		for (int l = 0; l < LANES; l++) begin
			if (l < DEPTH) begin
				lane_flag = lane_flag | cell_flag[l];
				lane_data = lane_data | cell_data[l];
			end
		end
	end

	// sweep counter and collection
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			grp_q      <= SCAN_W'(GROUPS - 1);
			hit_acc_q  <= 1'b0;
			data_acc_q <= '0;
		end else if (state_q == ST_SCAN) begin
			grp_q      <= grp_q - SCAN_W'(1);
			hit_acc_q  <= hit_acc_q | lane_flag;
			data_acc_q <= data_acc_q | lane_data;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_DONE) begin
			cnt_q <= cnt_next;
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			rsp_hit_q     <= hit_acc_q;
			rsp_learned_q <= learn_new;
			rsp_mac_q     <= data_acc_q;
			rsp_fill_q    <= FILL_W'(cnt_next);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.learned    = rsp_learned_q;
	assign rsp.entry_mac  = rsp_mac_q;
	assign rsp.fill_count = rsp_fill_q;

	// row of cells, cell 0 holds the oldest entry
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             sel_c;
		logic             valid_c;
		logic             app_c;
		logic [MAC_W-1:0] next_c;
		logic             flag_in_c;
		logic [MAC_W-1:0] data_in_c;

		assign sel_c   = (int'(pos_q) == i);
		assign valid_c = (int'(cnt_q) > i);
		assign app_c   = (int'(cnt_q) == i);

		// the new address enters at the tail when the row shifts
		if (i == DEPTH - 1) begin : g_tail
			assign next_c = mac_q;
		end else begin : g_body
			assign next_c = cell_mac[i+1];
		end

		// taps move LANES cells per cycle toward the head while the row is scanned
		if (i + LANES < DEPTH) begin : g_tap
			assign flag_in_c = cell_flag[i+LANES];
			assign data_in_c = cell_data[i+LANES];
		end else begin : g_tap_end
			assign flag_in_c = 1'b0;
			assign data_in_c = '0;
		end

		smlt_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.sel         (sel_c),
			.valid       (valid_c),
			.append      (app_c),
			.next_mac    (next_c),
			.tap_flag_in (flag_in_c),
			.tap_data_in (data_in_c),
			.mac         (cell_mac[i]),
			.tap_flag    (cell_flag[i]),
			.tap_data    (cell_data[i])
		);
	end

endmodule
`default_nettype wire
